### rtl/bwseg_pkg.sv
// ----------------------------------------------------------------------------
// bwseg_pkg
// Shared widths, constants, types and helpers for the bit-width segmentation
// datapath.
// ----------------------------------------------------------------------------
package bwseg_pkg;

	localparam int PIXEL_W    = 8;
	localparam int WIDTH_W    = 4;
	localparam int TOTAL_W    = 18;
	localparam int SEGLEN_W   = 9;
	localparam int HDR_W      = 5;
	localparam int MAXSEG_W   = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [HDR_W-1:0]    HDR_RESET    = 5'd11;
	localparam logic [MAXSEG_W-1:0] MAXSEG_RESET = 9'd256;
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 18'h3FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER_BITS = 2'd0,
		CFG_MAX_SEGMENT = 2'd1
	} cfg_reg_t;

	// Broadcast window controls for every cell.
	typedef struct packed {
		logic shift_w;
		logic clear;
		logic shift_c;
	} cell_ctl_t;

	// Fixed-width part of the token that walks the cell chain.
	typedef struct packed {
		logic               valid;
		logic [WIDTH_W-1:0] bmax;
		logic [WIDTH_W-1:0] best_w;
	} tok_t;

	typedef struct packed {
		logic [TOTAL_W-1:0]  total_bits;
		logic [SEGLEN_W-1:0] segment_length;
		logic [WIDTH_W-1:0]  segment_width;
	} res_t;

	// Bits needed to hold v; zero counts as one bit.
	function automatic logic [WIDTH_W-1:0] bit_len(input logic [PIXEL_W-1:0] v);
		logic [WIDTH_W-1:0] n;
		n = WIDTH_W'(1);
		for (int b = 1; b < PIXEL_W; b++) begin
			if (v[b]) begin
				n = WIDTH_W'(b + 1);
			end
		end
		return n;
	endfunction

endpackage

### rtl/bwseg_if.sv
// ----------------------------------------------------------------------------
// bwseg_if
// Valid/ready channels for pixels in and segmentation results out.
// ----------------------------------------------------------------------------
interface bwseg_pix_if import bwseg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	logic               start_req;

	modport source (output valid, output pixel, output start_req, input ready);
	modport sink (input valid, input pixel, input start_req, output ready);
endinterface

interface bwseg_res_if import bwseg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TOTAL_W-1:0]  total_bits;
	logic [SEGLEN_W-1:0] segment_length;
	logic [WIDTH_W-1:0]  segment_width;

	modport source (output valid, output total_bits, output segment_length,
		output segment_width, input ready);
	modport sink (input valid, input total_bits, input segment_length,
		input segment_width, output ready);
endinterface

### rtl/bwseg_cell.sv
// ----------------------------------------------------------------------------
// bwseg_cell
// One cell of the chain: holds the bit width and prefix cost K steps back and
// scores the candidate last segment of length K+1 as the token passes.
// ----------------------------------------------------------------------------
module bwseg_cell import bwseg_pkg::*; #(
	parameter int K           = 0,
	parameter int MAX_SEGMENT = 256,
	parameter int COST_BITS   = 18,
	localparam int LW         = $clog2(MAX_SEGMENT + 1),
	localparam int PROD_W     = LW + WIDTH_W,
	localparam int CAND_W     = ((COST_BITS > PROD_W) ? COST_BITS : PROD_W) + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [WIDTH_W-1:0]   w_prev,
	input  logic [COST_BITS-1:0] c_prev,
	output logic [WIDTH_W-1:0]   w_q,
	output logic [COST_BITS-1:0] c_q,
	input  tok_t                 tok_in,
	input  logic [CAND_W-1:0]    best_in,
	input  logic [LW-1:0]        len_in,
	input  logic [LW-1:0]        rem_in,
	output tok_t                 tok_q,
	output logic [CAND_W-1:0]    best_q,
	output logic [LW-1:0]        len_q,
	output logic [LW-1:0]        rem_q
);

	localparam int J = K + 1;

	logic [WIDTH_W-1:0] bmax;
	logic [PROD_W-1:0]  prod;
	logic [CAND_W-1:0]  cand;
	logic               active;
	logic               take;

	assign bmax   = (w_q > tok_in.bmax) ? w_q : tok_in.bmax;
	assign prod   = PROD_W'(J) * PROD_W'(bmax);
	assign cand   = CAND_W'(c_q) + CAND_W'(prod);
	assign active = tok_in.valid && (rem_in != '0);
	assign take   = active && ((K == 0) || (cand < best_in));

	// Window state: widths shift on a new pixel, costs as the token leaves the chain; both clear on image start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
			c_q <= '0;
		end else begin
			if (ctl.shift_w) begin
				w_q <= (ctl.clear && (K != 0)) ? '0 : w_prev;
			end
			if (ctl.shift_w && ctl.clear) begin
				c_q <= '0;
			end else if (ctl.shift_c) begin
				c_q <= c_prev;
			end
		end
	end

	// Advance the token by one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			best_q <= '0;
			len_q  <= '0;
			rem_q  <= '0;
		end else begin
			tok_q.valid  <= tok_in.valid;
			tok_q.bmax   <= bmax;
			tok_q.best_w <= take ? bmax : tok_in.best_w;
			best_q       <= take ? cand : best_in;
			len_q        <= take ? LW'(J) : len_in;
			rem_q        <= active ? rem_in - LW'(1) : '0;
		end
	end

endmodule

### rtl/bit_width_segmentation_dp_unit.sv
// ----------------------------------------------------------------------------
// bit_width_segmentation_dp_unit
// Segmentation DP over a stream of 8-bit gray pixels, one result per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one pixel and a start_req flag per transfer; start_req
//   clears the width and cost history before that pixel is scored. seg_out
//   carries the best total cost so far, the length of the last segment and
//   its bit width. cfg_we/cfg_index/cfg_data write header_bits (index 0) and
//   max_segment (index 1); other indexes are dropped. Write only when idle.
//   Timing: after a pixel transfer a token walks the chain of MAX_SEGMENT
//   cells, one cell per cycle, each cell scoring one candidate segment
//   length. The result is ready when the token leaves the last cell, and
//   pix_in.ready stays low until then, so the next pixel is taken only
//   after the chain walk of the last one has finished.
//   A two-deep result buffer (pending + output register) lets the next
//   pixel enter while a result waits; with both full, pix_in.ready drops
//   until seg_out takes a transfer.
//   Reset: header_bits=11, max_segment=256, all history cleared, so the
//   first pixel after reset acts as an image start.
// ----------------------------------------------------------------------------
module bit_width_segmentation_dp_unit import bwseg_pkg::*; #(
	parameter int MAX_SEGMENT = 256,
	parameter int COST_BITS   = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bwseg_pix_if.sink             pix_in,
	bwseg_res_if.source           seg_out
);

	localparam int N      = MAX_SEGMENT;
	localparam int CW     = COST_BITS;
	localparam int LW     = $clog2(N + 1);
	localparam int PROD_W = LW + WIDTH_W;
	localparam int CAND_W = ((CW > PROD_W) ? CW : PROD_W) + 1;
	localparam int SUM_W  = CAND_W + 1;
	localparam int MW     = ((LW > MAXSEG_W) ? LW : MAXSEG_W) + 1;
	localparam int OW     = (CW > TOTAL_W) ? CW : TOTAL_W;

	// Configuration registers.
	logic [HDR_W-1:0]    header_q;
	logic [MAXSEG_W-1:0] maxseg_q;

	// Control.
	logic          busy_q;
	logic          launch_q;
	logic [LW-1:0] rem_launch_q;
	logic [LW-1:0] items_q;
	logic          accept;
	logic          exit_vld;
	cell_ctl_t     ctl;

	// Result buffering.
	logic res_v_q;
	res_t res_q;
	logic out_v_q;
	res_t out_q;
	logic slot_free;
	res_t final_res;

	// Chain wiring: token index k feeds cell k, cell k drives index k+1.
	tok_t              tok  [0:N];
	logic [CAND_W-1:0] best [0:N];
	logic [LW-1:0]     len  [0:N];
	logic [LW-1:0]     rem  [0:N];
	logic [WIDTH_W-1:0] w_st [0:N-1];
	logic [CW-1:0]      c_st [0:N-1];
	logic [N:0]         tok_vld;

	logic [WIDTH_W-1:0] w_new;
	logic [SUM_W-1:0]   sum;
	logic [CW-1:0]      cost_new;
	logic [OW-1:0]      cost_ext;
	logic [LW+SEGLEN_W-1:0] len_ext;

	// Segment limit for the incoming pixel.
	logic [MW-1:0] ms_ext;
	logic [MW-1:0] seg_eff;
	logic [MW-1:0] base;
	logic [MW-1:0] lim;

	assign accept   = pix_in.valid && pix_in.ready;
	assign exit_vld = tok[N].valid;
	assign pix_in.ready = !busy_q && !res_v_q;

	assign ctl.shift_w = accept;
	assign ctl.clear   = accept && pix_in.start_req;
	assign ctl.shift_c = exit_vld;

	assign w_new = bit_len(pix_in.pixel);

	// Launch the token with an empty running max; cell 0 always takes it.
	assign tok[0].valid  = launch_q;
	assign tok[0].bmax   = '0;
	assign tok[0].best_w = '0;
	assign best[0]       = '0;
	assign len[0]        = '0;
	assign rem[0]        = rem_launch_q;

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			logic [WIDTH_W-1:0] w_prev;
			logic [CW-1:0]      c_prev;
			if (k == 0) begin : g_head
				assign w_prev = w_new;
				assign c_prev = cost_new;
			end else begin : g_body
				assign w_prev = w_st[k-1];
				assign c_prev = c_st[k-1];
			end
			bwseg_cell #(
				.K           (k),
				.MAX_SEGMENT (N),
				.COST_BITS   (CW)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.w_prev  (w_prev),
				.c_prev  (c_prev),
				.w_q     (w_st[k]),
				.c_q     (c_st[k]),
				.tok_in  (tok[k]),
				.best_in (best[k]),
				.len_in  (len[k]),
				.rem_in  (rem[k]),
				.tok_q   (tok[k+1]),
				.best_q  (best[k+1]),
				.len_q   (len[k+1]),
				.rem_q   (rem[k+1])
			);
		end
		for (k = 0; k <= N; k++) begin : g_vld
			assign tok_vld[k] = tok[k].valid;
		end
	endgenerate

	// Limit = min(pixels of this image including this one, clamped max_segment).
	always_comb begin
		ms_ext  = MW'(maxseg_q);
		seg_eff = ms_ext;
		if (ms_ext == '0) begin
			seg_eff = MW'(1);
		end else if (ms_ext > MW'(N)) begin
			seg_eff = MW'(N);
		end
		base = pix_in.start_req ? '0 : MW'(items_q);
		lim  = ((base + MW'(1)) < seg_eff) ? (base + MW'(1)) : seg_eff;
	end

	// Finish: add header, saturate into the cost window, then to the port width.
	always_comb begin
		sum      = SUM_W'(best[N]) + SUM_W'(header_q);
		cost_new = (sum > {{(SUM_W-CW){1'b0}}, {CW{1'b1}}}) ? '1 : sum[CW-1:0];
		cost_ext = OW'(cost_new);
		len_ext  = (LW+SEGLEN_W)'(len[N]);
		final_res.total_bits     = (cost_ext > OW'(TOTAL_MAX)) ? TOTAL_MAX
			: cost_ext[TOTAL_W-1:0];
		final_res.segment_length = len_ext[SEGLEN_W-1:0];
		final_res.segment_width  = tok[N].best_w;
	end

	// Configuration writes; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HDR_RESET;
			maxseg_q <= MAXSEG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_HEADER_BITS: header_q <= cfg_data[HDR_W-1:0];
				CFG_MAX_SEGMENT: maxseg_q <= cfg_data[MAXSEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold busy from pixel transfer until the token leaves the last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			items_q  <= '0;
		end else begin
			launch_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
				if (pix_in.start_req) begin
					items_q <= '0;
				end
			end else if (exit_vld) begin
				busy_q <= 1'b0;
				if (items_q < LW'(N)) begin
					items_q <= items_q + LW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_launch_q <= lim[LW-1:0];
		end
	end

	// Result buffer: go straight to the output register when it frees up,
	// otherwise park in the pending slot.
	assign slot_free = !out_v_q || seg_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (exit_vld) begin
				if (slot_free) begin
					out_v_q <= 1'b1;
				end else begin
					res_v_q <= 1'b1;
				end
			end else if (res_v_q && slot_free) begin
				out_v_q <= 1'b1;
				res_v_q <= 1'b0;
			end else if (seg_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_vld) begin
			if (slot_free) begin
				out_q <= final_res;
			end else begin
				res_q <= final_res;
			end
		end else if (res_v_q && slot_free) begin
			out_q <= res_q;
		end
	end

	assign seg_out.valid          = out_v_q;
	assign seg_out.total_bits     = out_q.total_bits;
	assign seg_out.segment_length = out_q.segment_length;
	assign seg_out.segment_width  = out_q.segment_width;

	// At most one token in flight along the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one token in the cell chain");

	// A token only leaves the chain while its pixel is still marked busy.
	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_vld |-> busy_q)
		else $error("token exit without a pixel in progress");

	// The pending slot is always empty when a new result comes out.
	a_pending_free: assert property (@(posedge clk) disable iff (!arst_n)
		exit_vld |-> !res_v_q)
		else $error("result arrived with pending slot full");

	// A pixel transfer launches exactly one token in the next cycle.
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (launch_q && busy_q))
		else $error("pixel transfer did not launch a token");

endmodule

### bench/bit_width_segmentation_dp_unit_tb.sv
// ----------------------------------------------------------------------------
// bit_width_segmentation_dp_unit_tb
// Streams gray pixels through the segmentation DP unit under random valid and
// ready gaps, and checks every result against a cycle-free segment-cost
// predictor. Header cost and segment limit are rewritten between phases.
// ----------------------------------------------------------------------------
module bit_width_segmentation_dp_unit_tb import bwseg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEG_DEPTH = 256;  // MAX_SEGMENT of the instance
	localparam int COST_W    = 18;   // COST_BITS of the instance
	localparam longint unsigned COST_CAP = (64'd1 << COST_W) - 1;

	// Indexes past the two real registers; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// The longest quiet stretch of a correct run is the deliberate receiver
	// hold plus one pixel's chain walk and the longest random gap; the limit
	// is several times that.
	localparam int HOLD_CYCLES    = 2000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 8;

	// Directed pixels: first pixel after reset without a start, every bit
	// length and its boundaries, a start in mid-stream, a one-pixel image.
	localparam int N_DIRECTED = 22;
	localparam logic [PIXEL_W-1:0] DIR_PIXELS [N_DIRECTED] = '{
		8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd8, 8'd15, 8'd16, 8'd31,
		8'd32, 8'd63, 8'd64, 8'd127, 8'd128, 8'd255, 8'd0, 8'd170, 8'd85,
		8'd0, 8'd255
	};
	localparam logic [N_DIRECTED-1:0] DIR_START = 22'b11_0100_0000_0000_0000_0000;

	// ------------------------------------------------------------------------
	// Segment-cost predictor and store of expected results
	// ------------------------------------------------------------------------
	class segcost_predictor;
		logic [HDR_W-1:0]    header_bits;
		logic [MAXSEG_W-1:0] max_segment;
		logic [WIDTH_W-1:0]  width_hist [SEG_DEPTH];  // k = pixels back
		logic [COST_W-1:0]   cost_hist [SEG_DEPTH];   // k = prefix ending k+1 back
		int                  pixels_in_image;
		res_t                expected_q [$];
		int                  errors;

		function new();
			header_bits = HDR_RESET;
			max_segment = MAXSEG_RESET;
			errors      = 0;
			clear_history();
		endfunction

		function void clear_history();
			for (int k = 0; k < SEG_DEPTH; k++) begin
				width_hist[k] = '0;
				cost_hist[k]  = '0;
			end
			pixels_in_image = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_HEADER_BITS: header_bits = data[HDR_W-1:0];
				CFG_MAX_SEGMENT: max_segment = data[MAXSEG_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Score one accepted pixel and queue the result it must produce.
		function void take_pixel(logic [PIXEL_W-1:0] px, logic start);
			int unsigned     limit;
			int unsigned     bmax;
			longint unsigned best;
			longint unsigned cand;
			res_t            r;
			if (start) begin
				clear_history();
			end
			for (int k = SEG_DEPTH - 1; k > 0; k--) begin
				width_hist[k] = width_hist[k-1];
			end
			width_hist[0] = (px == 0) ? WIDTH_W'(1) : WIDTH_W'($clog2(int'(px) + 1));

			// zero acts as one, anything past the window as the window
			limit = (max_segment == 0) ? 1 :
				((max_segment > SEG_DEPTH) ? SEG_DEPTH : max_segment);
			if (pixels_in_image + 1 < limit) begin
				limit = pixels_in_image + 1;
			end

			bmax             = 0;
			best             = 0;
			r.segment_length = SEGLEN_W'(1);
			r.segment_width  = width_hist[0];
			for (int j = 1; j <= limit; j++) begin
				if (width_hist[j-1] > bmax) begin
					bmax = width_hist[j-1];
				end
				cand = cost_hist[j-1];
				cand += j * bmax;
				// strict compare: a tie keeps the shorter segment
				if (j == 1 || cand < best) begin
					best             = cand;
					r.segment_length = SEGLEN_W'(j);
					r.segment_width  = WIDTH_W'(bmax);
				end
			end
			best += header_bits;
			if (best > COST_CAP) begin
				best = COST_CAP;
			end

			for (int k = SEG_DEPTH - 1; k > 0; k--) begin
				cost_hist[k] = cost_hist[k-1];
			end
			cost_hist[0] = COST_W'(best);
			if (pixels_in_image < SEG_DEPTH) begin
				pixels_in_image++;
			end

			r.total_bits = (best > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(best);
			expected_q.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void match_result(logic [TOTAL_W-1:0] total, logic [SEGLEN_W-1:0] len,
				logic [WIDTH_W-1:0] wid);
			res_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: total_bits=%0d length=%0d width=%0d",
					$time, total, len, wid);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (total !== want.total_bits) begin
				$display("%0t: total_bits mismatch: expected %0d, actual %0d",
					$time, want.total_bits, total);
				errors++;
			end
			if (len !== want.segment_length) begin
				$display("%0t: segment_length mismatch: expected %0d, actual %0d",
					$time, want.segment_length, len);
				errors++;
			end
			if (wid !== want.segment_width) begin
				$display("%0t: segment_width mismatch: expected %0d, actual %0d",
					$time, want.segment_width, wid);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bwseg_pix_if pix ();
	bwseg_res_if res ();

	bit_width_segmentation_dp_unit #(
		.MAX_SEGMENT(SEG_DEPTH),
		.COST_BITS  (COST_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_in   (pix),
		.seg_out  (res)
	);

	segcost_predictor pred = new();

	logic pix_taken;     // a pixel transfer happened at the last rising edge
	int   idle_cycles;   // rising edges in a row with no transfer on either side
	bit   calm;          // both sides run with no idling while set
	bit   hold_req;      // asks the receiver for one long hold

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both channels and the register port at the rising edge.
	// Everything here sees the values from before the edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		pix_taken <= pix.valid && pix.ready;
		if (arst_n) begin
			if (cfg_we) begin
				pred.write_reg(cfg_index, cfg_data);
			end
			if (pix.valid && pix.ready) begin
				pred.take_pixel(pix.pixel, pix.start_req);
			end
			if (res.valid && res.ready) begin
				pred.match_result(res.total_bits, res.segment_length, res.segment_width);
			end
			if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
		end
		$display("bit_width_segmentation_dp_unit_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: alternate stalls and ready stretches. Stall lengths are mostly
	// zero or short, with a few long ones so stalls land on every part of the
	// chain walk. A hold request overrides the draw once.
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		int r;
		res.ready <= 1'b0;
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end else if (calm || r < 50) begin
				stall = 0;
			end else if (r < 85) begin
				stall = $urandom_range(1, 6);
			end else if (r < 96) begin
				stall = $urandom_range(7, 60);
			end else begin
				stall = $urandom_range(100, 500);
			end
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks. Each is entered and left at a falling edge.
	// ------------------------------------------------------------------------

	// Offer one pixel after a random gap and hold it until the transfer.
	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic start);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			gap = 0;
		end else if (r < 88) begin
			gap = $urandom_range(1, 4);
		end else if (r < 97) begin
			gap = $urandom_range(5, 40);
		end else begin
			gap = $urandom_range(100, 400);
		end
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid     <= 1'b1;
		pix.pixel     <= px;
		pix.start_req <= start;
		do begin
			@(negedge clk);
		end while (!pix_taken);
	endtask

	// Image content: runs of pixels limited to one bit length so that long
	// segments pay off, with the odd full-range outlier and random starts.
	task automatic send_stream(input int n, input int start_pct);
		int                 run_w;
		int                 run_left;
		int                 w;
		logic [PIXEL_W-1:0] px;
		logic               start;
		run_w    = PIXEL_W;
		run_left = 0;
		for (int i = 0; i < n; i++) begin
			if (run_left == 0) begin
				run_w    = $urandom_range(1, PIXEL_W);
				run_left = $urandom_range(1, 40);
			end
			run_left--;
			w = $urandom_range(1, run_w);
			if ($urandom_range(0, 19) == 0) begin
				px = PIXEL_W'($urandom);
			end else if (w == 1) begin
				px = PIXEL_W'($urandom_range(0, 1));
			end else begin
				px = PIXEL_W'($urandom_range((1 << w) - 1, 1 << (w - 1)));
			end
			start = (start_pct > 0) && (i == 0 || $urandom_range(0, 99) < start_pct);
			send_pixel(px, start);
		end
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic settle();
		pix.valid <= 1'b0;
		while (pred.pending() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write, taken at the rising edge in between.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_HEADER_BITS;
		cfg_data      <= '0;
		pix.valid     <= 1'b0;
		pix.pixel     <= '0;
		pix.start_req <= 1'b0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed pixels at the reset settings.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_pixel(DIR_PIXELS[i], DIR_START[i]);
		end
		settle();

		// No header cost, limit of zero (acts as one); spare indexes are dropped.
		cfg_write(CFG_HEADER_BITS, CFG_DATA_W'(0));
		cfg_write(CFG_MAX_SEGMENT, CFG_DATA_W'(0));
		cfg_write(CFG_SPARE_2, CFG_DATA_W'(9'h1FF));
		cfg_write(CFG_SPARE_3, CFG_DATA_W'(9'h0AA));
		send_stream(60, 10);
		settle();

		// Largest header cost with single-pixel segments.
		cfg_write(CFG_HEADER_BITS, CFG_DATA_W'(31));
		cfg_write(CFG_MAX_SEGMENT, CFG_DATA_W'(1));
		send_stream(40, 8);
		settle();

		// Short limit. Partway through, hold the receiver long enough that the
		// result buffer fills and pixel transfers stall, while pixels keep
		// coming with no gaps. Then pause until everything has drained.
		cfg_write(CFG_HEADER_BITS, CFG_DATA_W'(7));
		cfg_write(CFG_MAX_SEGMENT, CFG_DATA_W'(3));
		send_stream(30, 5);
		calm     = 1'b1;
		hold_req = 1'b1;
		send_stream(14, 0);
		calm = 1'b0;
		send_stream(10, 0);
		settle();
		send_stream(26, 5);
		settle();

		// One long image past the window with an oversized limit: the history
		// fills completely and the pixel count saturates. Start it calm.
		cfg_write(CFG_HEADER_BITS, CFG_DATA_W'(11));
		cfg_write(CFG_MAX_SEGMENT, CFG_DATA_W'(300));
		calm = 1'b1;
		send_pixel(PIXEL_W'($urandom), 1'b1);
		send_stream(59, 0);
		calm = 1'b0;
		send_stream(240, 0);
		settle();

		// Full-window limit written explicitly, heavy header.
		cfg_write(CFG_MAX_SEGMENT, CFG_DATA_W'(SEG_DEPTH));
		cfg_write(CFG_HEADER_BITS, CFG_DATA_W'(31));
		send_stream(80, 3);
		settle();

		// Random header and a small random limit.
		cfg_write(CFG_HEADER_BITS, CFG_DATA_W'($urandom_range(0, 31)));
		cfg_write(CFG_MAX_SEGMENT, CFG_DATA_W'($urandom_range(2, 20)));
		send_stream(60, 6);
		settle();

		// Free header and the largest encodable limit.
		cfg_write(CFG_HEADER_BITS, CFG_DATA_W'(0));
		cfg_write(CFG_MAX_SEGMENT, CFG_DATA_W'(511));
		send_stream(50, 4);

		// Drain, then give the chain one more walk to show nothing stray.
		settle();
		repeat (SEG_DEPTH + 16) @(negedge clk);
		if (pred.errors == 0 && pred.pending() == 0) begin
			$display("bit_width_segmentation_dp_unit_tb: PASS");
		end else begin
			$display("bit_width_segmentation_dp_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
